@@ sv/chained_bucket_hash_table_macros.svh @@
// assertion macros for the chained bucket hash table
// used by the top level only
`ifndef CHAINED_BUCKET_HASH_TABLE_MACROS_SVH
`define CHAINED_BUCKET_HASH_TABLE_MACROS_SVH
// implication checked every clock outside reset
`define CBHT_ASSERT_IMP(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("assertion failed");
// next-cycle implication outside reset
`define CBHT_ASSERT_NXT(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("assertion failed");
`endif

@@ sv/cbht_pkg.sv @@
// shared types and constants for the chained bucket hash table
// no dependencies
`default_nettype none
package cbht_pkg;
  localparam int MaxBuckets = 1024;
  localparam int Epl = 8;
  localparam int OvfLines = 256;
  localparam int MaxEmit = 64;
  localparam int NLines = MaxBuckets + OvfLines;
  localparam int NEntries = NLines * Epl;

  localparam logic [2:0] OpInsert = 3'd0;
  localparam logic [2:0] OpLookup = 3'd1;
  localparam logic [2:0] OpReplace = 3'd2;
  localparam logic [2:0] OpRemove = 3'd3;
  localparam logic [2:0] OpScan = 3'd4;

  localparam logic [2:0] StOk = 3'd0;
  localparam logic [2:0] StNone = 3'd1;
  localparam logic [2:0] StZeroRef = 3'd2;
  localparam logic [2:0] StPoolOut = 3'd3;
  localparam logic [2:0] StTrunc = 3'd4;
  localparam logic [2:0] StBadLoc = 3'd5;

  typedef struct packed {
    logic [2:0]  op;
    logic [63:0] key_hash;
    logic [46:0] new_reference;
    logic [10:0] line_index;
    logic [2:0]  slot_index;
    logic [9:0]  bucket_index;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [46:0] found_reference;
    logic [10:0] found_line;
    logic [2:0]  found_slot;
    logic        last;
    logic [6:0]  result_count;
  } rsp_t;
endpackage
`default_nettype wire

@@ sv/chained_bucket_hash_table.sv @@
// chained bucket hash table: sequencer, entry memory, result register
// depends on cbht_pkg and chained_bucket_hash_table_macros.svh
// a refused command gets its result at accept; else busy stays high while each entry
// visited takes S_RD, S_EVAL, a new pool line S_MOVE, S_ZERO, S_LINK, and a walk S_FIN
// a clearing pass over all 10240 entries follows reset; start is refused meanwhile
// next command accepted in the cycle of the last result; the receiver cannot stall
`default_nettype none
`include "chained_bucket_hash_table_macros.svh"
module chained_bucket_hash_table (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  output logic                 busy,
  input  wire cbht_pkg::req_t  req,
  input  wire logic            cfg_we,
  input  wire logic [3:0]      cfg_wdata,
  output logic                 strobe,
  output cbht_pkg::rsp_t       rsp
);
  typedef enum logic [7:0] {
    S_CLEAR = 8'b00000001,
    S_IDLE  = 8'b00000010,
    S_RD    = 8'b00000100,
    S_EVAL  = 8'b00001000,
    S_MOVE  = 8'b00010000,
    S_LINK  = 8'b00100000,
    S_ZERO  = 8'b01000000,
    S_FIN   = 8'b10000000
  } state_t;

  state_t state;
  logic [13:0] addr;
  logic [10:0] line;
  logic [2:0]  slot;
  logic [3:0]  bucket_bits;
  logic [8:0]  ovf_used;
  logic        ovf_full;
  cbht_pkg::req_t cur;
  logic [63:0] rdata;
  logic [63:0] moved;
  logic [10:0] new_line;
  logic [8:0]  steps;
  logic [6:0]  count;
  logic        pend;
  cbht_pkg::rsp_t pend_rsp;

  // entry memory
  logic [63:0] mem [cbht_pkg::NEntries];
  logic        we;
  logic [13:0] waddr;
  logic [63:0] wdata;
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[addr];
  end

  logic [15:0] tag;
  assign tag = cur.key_hash[63:48];
  logic is_ref, is_free, is_link;
  assign is_ref = !rdata[47] && rdata[46:0] != '0;
  assign is_free = rdata[46:0] == '0;
  assign is_link = rdata[47] && rdata[46:0] < 47'(cbht_pkg::NLines)
                   && rdata[10:0] != line;
  logic is_walk, match;
  assign is_walk = cur.op == cbht_pkg::OpLookup || cur.op == cbht_pkg::OpScan;
  assign match = is_ref && (cur.op == cbht_pkg::OpScan || rdata[63:48] == tag);

  assign busy = state != S_IDLE;

  function automatic logic [13:0] ad(input logic [10:0] l, input logic [2:0] s);
    ad = {l, s};
  endfunction

  // bucket of a key
  function automatic logic [9:0] kbucket_of(input logic [63:0] h);
    logic [19:0] m;
    m = 20'((21'd1 << bucket_bits) - 21'd1);
    kbucket_of = 10'(h[19:0] & m);
  endfunction

  // single-result finish used by all non-walk paths
  task automatic emit(input logic [2:0] st, input logic [46:0] r,
                      input logic [10:0] l, input logic [2:0] s);
    strobe <= 1'b1;
    rsp <= '{st, r, l, s, 1'b1, 7'd1};
    state <= S_IDLE;
  endtask

  // sequencer
  always_ff @(posedge clk) begin
    we <= 1'b0;
    strobe <= 1'b0;
    if (cfg_we) bucket_bits <= cfg_wdata;
    if (rst) begin
      state <= S_CLEAR;
      addr <= '0;
      ovf_used <= '0;
      ovf_full <= 1'b0;
      bucket_bits <= 4'd10;
      pend <= 1'b0;
    end else begin
      case (state)
        // clearing pass over the memory
        S_CLEAR: begin
          we <= 1'b1;
          waddr <= addr;
          wdata <= '0;
          addr <= addr + 14'd1;
          if (addr == 14'(cbht_pkg::NEntries - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            cur <= req;
            count <= '0;
            pend <= 1'b0;
            steps <= '0;
            state <= S_RD;
            slot <= '0;
            case (req.op)
              cbht_pkg::OpInsert: begin
                line <= 11'(kbucket_of(req.key_hash));
                addr <= ad(11'(kbucket_of(req.key_hash)), 3'd0);
                if (req.new_reference == '0) begin
                  emit(cbht_pkg::StZeroRef, '0, '0, '0);
                end
              end
              cbht_pkg::OpLookup: begin
                line <= 11'(kbucket_of(req.key_hash));
                addr <= ad(11'(kbucket_of(req.key_hash)), 3'd0);
              end
              cbht_pkg::OpReplace, cbht_pkg::OpRemove: begin
                line <= req.line_index;
                slot <= req.slot_index;
                addr <= ad(req.line_index, req.slot_index);
                if (req.line_index >= 11'(cbht_pkg::NLines))
                  emit(cbht_pkg::StBadLoc, '0, '0, '0);
              end
              cbht_pkg::OpScan: begin
                line <= {1'b0, req.bucket_index};
                addr <= ad({1'b0, req.bucket_index}, 3'd0);
              end
              default: emit(cbht_pkg::StBadLoc, '0, '0, '0);
            endcase
          end
        end
        S_RD: state <= S_EVAL;
        S_EVAL: begin
          state <= S_RD;
          case (cur.op)
            cbht_pkg::OpInsert: begin
              if (is_free) begin
                we <= 1'b1; waddr <= addr;
                wdata <= {tag, 1'b0, cur.new_reference};
                emit(cbht_pkg::StOk, cur.new_reference, line, slot);
              end else if (slot != 3'(cbht_pkg::Epl - 1)) begin
                slot <= slot + 3'd1; addr <= addr + 14'd1;
              end else if (is_link) begin
                line <= rdata[10:0]; slot <= '0; addr <= ad(rdata[10:0], 3'd0);
              end else if (ovf_full) begin
                emit(cbht_pkg::StPoolOut, '0, '0, '0);
              end else begin
                moved <= rdata;
                new_line <= 11'(cbht_pkg::MaxBuckets) + 11'(ovf_used);
                ovf_used <= ovf_used + 9'd1;
                if (ovf_used == 9'(cbht_pkg::OvfLines - 1)) ovf_full <= 1'b1;
                state <= S_MOVE;
              end
            end
            cbht_pkg::OpReplace, cbht_pkg::OpRemove: begin
              if (!is_ref) emit(cbht_pkg::StBadLoc, '0, '0, '0);
              else if (cur.op == cbht_pkg::OpRemove) begin
                we <= 1'b1; waddr <= addr; wdata <= '0;
                emit(cbht_pkg::StOk, rdata[46:0], line, slot);
              end else if (cur.new_reference == '0) begin
                emit(cbht_pkg::StZeroRef, '0, '0, '0);
              end else begin
                we <= 1'b1; waddr <= addr;
                wdata <= {tag, 1'b0, cur.new_reference};
                emit(cbht_pkg::StOk, cur.new_reference, line, slot);
              end
            end
            default: begin
              // walk: hold one result back so last can be marked
              if (match) begin
                if (count == 7'(cbht_pkg::MaxEmit)) begin
                  pend_rsp.status <= cbht_pkg::StTrunc;
                end else begin
                  if (pend) begin
                    strobe <= 1'b1;
                    rsp <= pend_rsp;
                  end
                  pend <= 1'b1;
                  count <= count + 7'd1;
                  pend_rsp <= '{cbht_pkg::StOk, rdata[46:0], line, slot, 1'b0,
                                count + 7'd1};
                end
              end
              if (slot != 3'(cbht_pkg::Epl - 1)) begin
                slot <= slot + 3'd1; addr <= addr + 14'd1;
              end else if (is_link && steps != 9'(cbht_pkg::OvfLines)) begin
                steps <= steps + 9'd1;
                line <= rdata[10:0]; slot <= '0; addr <= ad(rdata[10:0], 3'd0);
              end else begin
                state <= S_FIN;
              end
            end
          endcase
        end
        // move last entry to slot 0 of new line
        S_MOVE: begin
          we <= 1'b1; waddr <= ad(new_line, 3'd0); wdata <= moved;
          slot <= 3'd1;
          state <= S_ZERO;
        end
        S_ZERO: begin
          we <= 1'b1; waddr <= ad(new_line, slot); wdata <= '0;
          slot <= slot + 3'd1;
          if (slot == 3'(cbht_pkg::Epl - 1)) state <= S_LINK;
        end
        // link old last slot to new line; insert goes to slot 1
        S_LINK: begin
          we <= 1'b1; waddr <= ad(line, 3'(cbht_pkg::Epl - 1));
          wdata <= {16'd0, 1'b1, 36'd0, new_line};
          line <= new_line; slot <= 3'd1; addr <= ad(new_line, 3'd1);
          state <= S_RD;
        end
        S_FIN: begin
          strobe <= 1'b1;
          state <= S_IDLE;
          if (pend) begin
            rsp <= '{pend_rsp.status, pend_rsp.found_reference, pend_rsp.found_line,
                     pend_rsp.found_slot, 1'b1, pend_rsp.result_count};
          end else begin
            rsp <= '{cbht_pkg::StNone, '0, '0, '0, 1'b1, 7'd1};
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `CBHT_ASSERT_IMP(a_clear_quiet, state == S_CLEAR, !strobe)
  `CBHT_ASSERT_IMP(a_count_nonzero, strobe, rsp.result_count != 7'd0)
  `CBHT_ASSERT_IMP(a_count_max, strobe, rsp.result_count <= 7'(cbht_pkg::MaxEmit))
  `CBHT_ASSERT_IMP(a_last_idle, strobe && rsp.last, state == S_IDLE)
  `CBHT_ASSERT_NXT(a_move_zero, state == S_MOVE, state == S_ZERO)
endmodule
`default_nettype wire
